[design/dcls_pkg.sv]
// Shared constants, types and tables for the DRAM CAS latency select block.
`default_nettype none
package dcls_pkg;

   // Field widths
   localparam int MaskWidth  = 8;
   localparam int CycleWidth = 8;
   localparam int BusWidth   = 10;
   localparam int CodeWidth  = 3;
   localparam int StatWidth  = 2;
   localparam int BitIdxWidth = $clog2(MaskWidth);

   // Timing decode constants
   localparam logic [17:0] SpeedDividend = 18'd20000;
   localparam logic [MaskWidth-1:0] EmptyMask = 8'hFF;
   localparam logic [3:0] NibbleMask = 4'hF;
   localparam logic [BusWidth-1:0] BusSpeedReset = 10'd400;

   // Result status codes
   localparam logic [StatWidth-1:0] StatusOk       = 2'd0;
   localparam logic [StatWidth-1:0] StatusNoSlot   = 2'd1;
   localparam logic [StatWidth-1:0] StatusNoCommon = 2'd2;

   typedef logic [MaskWidth-1:0] mask_type;

   // Lane result handed to the merge stage
   typedef struct packed {
      mask_type map0;
      mask_type map1;
   } lane_pair_type;

   // Result beat contents
   typedef struct packed {
      logic [CodeWidth-1:0] cas_code;
      logic [StatWidth-1:0] status;
   } result_type;

   // Controller CAS field value for each latency bit position
   function automatic logic [CodeWidth-1:0] cas_lookup(input logic [BitIdxWidth-1:0] idx);
      logic [CodeWidth-1:0] code;
      case (idx)
         3'd0:    code = 3'd5;
         3'd1:    code = 3'd5;
         3'd2:    code = 3'd2;
         3'd3:    code = 3'd6;
         3'd4:    code = 3'd3;
         3'd5:    code = 3'd7;
         3'd6:    code = 3'd4;
         default: code = 3'd0;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

[design/dcls_intf.sv]
// Request and response channel interfaces for the DRAM CAS latency select block.
`default_nettype none
interface dcls_req_if;
   logic                               valid;
   logic                               ready;
   logic [dcls_pkg::MaskWidth-1:0]     slot0_cas_mask;
   logic [dcls_pkg::CycleWidth-1:0]    slot0_cycle_half;
   logic [dcls_pkg::CycleWidth-1:0]    slot0_cycle_one;
   logic [dcls_pkg::MaskWidth-1:0]     slot1_cas_mask;
   logic [dcls_pkg::CycleWidth-1:0]    slot1_cycle_half;
   logic [dcls_pkg::CycleWidth-1:0]    slot1_cycle_one;

   modport source (
      output valid, slot0_cas_mask, slot0_cycle_half, slot0_cycle_one,
             slot1_cas_mask, slot1_cycle_half, slot1_cycle_one,
      input  ready
   );
   modport sink (
      input  valid, slot0_cas_mask, slot0_cycle_half, slot0_cycle_one,
             slot1_cas_mask, slot1_cycle_half, slot1_cycle_one,
      output ready
   );
endinterface

interface dcls_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [dcls_pkg::CodeWidth-1:0]     cas_code;
   logic [dcls_pkg::StatWidth-1:0]     status;

   modport source (output valid, cas_code, status, input ready);
   modport sink (input valid, cas_code, status, output ready);
endinterface
`default_nettype wire

[design/dram_cas_latency_select_core.sv]
// Top level of the DRAM CAS latency select block: two slot lanes, merge and output register.
// Throughput: one beat per cycle; the lane register and the output register form a
// two-stage pipeline that stalls only when the response side holds ready low.
// Reset (synchronous, active high) empties both stages and sets the bus speed to 400 MHz.
`default_nettype none
module dram_cas_latency_select_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [dcls_pkg::BusWidth-1:0] csr_wr_data,
   dcls_req_if.sink                           req_if,
   dcls_rsp_if.source                         rsp_if
);

   logic [dcls_pkg::BusWidth-1:0] bus_speed_ff;
   logic                          lane_valid_ff;
   dcls_pkg::lane_pair_type       lane_ff;
   dcls_pkg::lane_pair_type       lane_in;
   logic                          out_valid_ff;
   dcls_pkg::result_type          out_ff;
   dcls_pkg::result_type          out_in;
   logic                          out_free;
   logic                          req_beat;

   // Bus speed register
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_speed_ff <= dcls_pkg::BusSpeedReset;
      end else if (csr_wr_en) begin
         bus_speed_ff <= csr_wr_data;
      end
   end

   // Slot lanes
   dcls_lane u_lane0 (
      .cas_mask   (req_if.slot0_cas_mask),
      .cycle_half (req_if.slot0_cycle_half),
      .cycle_one  (req_if.slot0_cycle_one),
      .bus_speed  (bus_speed_ff),
      .slot_map   (lane_in.map0)
   );

   dcls_lane u_lane1 (
      .cas_mask   (req_if.slot1_cas_mask),
      .cycle_half (req_if.slot1_cycle_half),
      .cycle_one  (req_if.slot1_cycle_one),
      .bus_speed  (bus_speed_ff),
      .slot_map   (lane_in.map1)
   );

   // Handshake: advance whenever the lane stage is empty or the output stage can take a beat
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = !lane_valid_ff || out_free;
   assign req_beat     = req_if.valid && req_if.ready;

   // Lane stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         lane_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         lane_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         lane_ff <= lane_in;
      end
   end

   // Merge lanes
   dcls_merge u_merge (
      .lanes  (lane_ff),
      .result (out_in)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= lane_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && lane_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.cas_code = out_ff.cas_code;
   assign rsp_if.status   = out_ff.status;

endmodule
`default_nettype wire

[design/dcls_lane.sv]
// One slot lane: timing check against the bus speed and trimming of the CAS bitmap.
`default_nettype none
module dcls_lane (
   input  wire logic [dcls_pkg::MaskWidth-1:0]  cas_mask,
   input  wire logic [dcls_pkg::CycleWidth-1:0] cycle_half,
   input  wire logic [dcls_pkg::CycleWidth-1:0] cycle_one,
   input  wire logic [dcls_pkg::BusWidth-1:0]   bus_speed,
   output dcls_pkg::mask_type                   slot_map
);

   // Speed 20000/denom meets the bus exactly when bus*denom <= 20000
   function automatic logic timing_meets(input logic [dcls_pkg::CycleWidth-1:0] cyc,
                                         input logic [dcls_pkg::BusWidth-1:0] bus);
      logic [7:0]  denom;
      logic [17:0] prod;
      denom = 8'({4'd0, cyc[7:4] & dcls_pkg::NibbleMask}) * 8'd10
            + 8'({4'd0, cyc[3:0] & dcls_pkg::NibbleMask});
      prod  = 18'(denom) * 18'(bus);
      return (cyc != '0) && (denom != '0) && (prod <= dcls_pkg::SpeedDividend);
   endfunction

   logic                                 half_ok;
   logic                                 one_ok;
   logic [1:0]                           shift;
   logic [dcls_pkg::BitIdxWidth-1:0]     top;
   logic                                 empty;

   // Pick how many low-latency bits the timings allow
   always_comb begin
      half_ok = timing_meets(cycle_half, bus_speed);
      one_ok  = timing_meets(cycle_one, bus_speed);
      if (half_ok && one_ok) begin
         shift = 2'd2;
      end else if (half_ok) begin
         shift = 2'd1;
      end else begin
         shift = 2'd0;
      end
   end

   // Find the highest supported latency bit
   always_comb begin
      top = '0;
      for (int i = 0; i < dcls_pkg::MaskWidth; i++) begin
         if (cas_mask[i]) begin
            top = dcls_pkg::BitIdxWidth'(i);
         end
      end
   end

   // Keep bits at or above top minus shift; drop empty slots
   always_comb begin
      empty = (cas_mask == dcls_pkg::EmptyMask) || (cas_mask == '0);
      if (empty) begin
         slot_map = '0;
      end else if ({1'b0, top} >= {2'b0, shift}) begin
         slot_map = cas_mask & (dcls_pkg::EmptyMask << (top - dcls_pkg::BitIdxWidth'(shift)));
      end else begin
         slot_map = cas_mask;
      end
   end

endmodule
`default_nettype wire

[design/dcls_merge.sv]
// Merge stage: intersect the slot bitmaps, or take the one non-empty bitmap, and map its lowest set bit to a CAS code.
`default_nettype none
module dcls_merge (
   input  wire dcls_pkg::lane_pair_type lanes,
   output dcls_pkg::result_type         result
);

   dcls_pkg::mask_type               pick;
   logic [dcls_pkg::BitIdxWidth-1:0] low;

   // Choose the bitmap that decides
   always_comb begin
      if (lanes.map0 == '0) begin
         pick = lanes.map1;
      end else if (lanes.map1 == '0) begin
         pick = lanes.map0;
      end else begin
         pick = lanes.map0 & lanes.map1;
      end
   end

   // Find the lowest set bit, top position when none
   always_comb begin
      low = dcls_pkg::BitIdxWidth'(dcls_pkg::MaskWidth - 1);
      for (int i = dcls_pkg::MaskWidth - 1; i >= 0; i--) begin
         if (pick[i]) begin
            low = dcls_pkg::BitIdxWidth'(i);
         end
      end
   end

   // Build code and status
   always_comb begin
      if ((lanes.map0 == '0) && (lanes.map1 == '0)) begin
         result.cas_code = '0;
         result.status   = dcls_pkg::StatusNoSlot;
      end else if (pick == '0) begin
         result.cas_code = '0;
         result.status   = dcls_pkg::StatusNoCommon;
      end else begin
         result.cas_code = dcls_pkg::cas_lookup(low);
         result.status   = dcls_pkg::StatusOk;
      end
   end

endmodule
`default_nettype wire

[design/dcls_checker.sv]
// Port-level checker for the DRAM CAS latency select block, bound to its top level.
`default_nettype none
module dcls_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [dcls_pkg::CodeWidth-1:0] rsp_cas_code,
   input wire logic [dcls_pkg::StatWidth-1:0] rsp_status
);

   // Status stays within its defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == dcls_pkg::StatusOk ||
                     rsp_status == dcls_pkg::StatusNoSlot ||
                     rsp_status == dcls_pkg::StatusNoCommon))
      else $error("response status out of range");

   // Error results carry a zero code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != dcls_pkg::StatusOk) |-> (rsp_cas_code == '0))
      else $error("nonzero CAS code on error status");

   // A new response follows an accepted request beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response without matching request beat");

   // Input stalls only under output backpressure
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without response backpressure");

   // Held response stays valid
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before it was taken");

endmodule

bind dram_cas_latency_select_core dcls_checker u_dcls_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_cas_code (rsp_if.cas_code),
   .rsp_status   (rsp_if.status)
);
`default_nettype wire
